// ----- design/gbn_pkg.sv -----
// ============================================================================
// gbn_pkg: shared types for the Go-Back-N ARQ endpoint
// Operation codes, result kinds and the result control group.
// ============================================================================
package gbn_pkg;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_PEER    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_RESET   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_RETX    = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  window_full;
        logic  last;
    } t_res_ctrl;

endpackage

// ----- design/gbn_fifo.sv -----
// ============================================================================
// gbn_fifo: two-entry queue
// Registered storage with full/empty flags; push and pop may coincide.
// ============================================================================
module gbn_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_do_push;
        n_rd_ptr = r_rd_ptr ^ w_do_pop;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/gbn_front.sv -----
// ============================================================================
// gbn_front: intake and classification
// Decode the operation, keep only the handle field it uses, and queue it.
// ============================================================================
module gbn_front #(
    parameter int SEQ_BITS    = 3,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_operation,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    input  logic [HANDLE_BITS-1:0] i_rx_payload,
    input  logic [SEQ_BITS-1:0]    i_rx_seq,
    input  logic [SEQ_BITS-1:0]    i_rx_ack,
    output logic                   o_cmd_valid,
    output gbn_pkg::t_op           o_cmd_op,
    output logic [HANDLE_BITS-1:0] o_cmd_data,
    output logic [SEQ_BITS-1:0]    o_cmd_seq,
    output logic [SEQ_BITS-1:0]    o_cmd_ack,
    input  logic                   i_cmd_pop
);

    localparam int CMD_W = 2 + HANDLE_BITS + 2 * SEQ_BITS;

    gbn_pkg::t_op           w_op;
    logic [HANDLE_BITS-1:0] w_data;
    logic [CMD_W-1:0]       w_in_word, w_out_word;
    logic                   w_empty;

    // select the handle that matters for this operation
    always_comb begin
        w_op = gbn_pkg::t_op'(i_operation);
        case (w_op)
            gbn_pkg::OP_SEND: w_data = i_frame_handle;
            gbn_pkg::OP_PEER: w_data = i_rx_payload;
            default:          w_data = '0;
        endcase
    end

    assign w_in_word = {w_op, w_data, i_rx_seq, i_rx_ack};

    gbn_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_word),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_empty (w_empty),
        .o_data  (w_out_word)
    );

    assign o_cmd_valid = !w_empty;
    assign o_cmd_op    = gbn_pkg::t_op'(w_out_word[CMD_W-1 -: 2]);
    assign o_cmd_data  = w_out_word[2*SEQ_BITS +: HANDLE_BITS];
    assign o_cmd_seq   = w_out_word[SEQ_BITS +: SEQ_BITS];
    assign o_cmd_ack   = w_out_word[0 +: SEQ_BITS];

endmodule

// ----- design/gbn_back.sv -----
// ============================================================================
// gbn_back: protocol engine
// Hold window counters and the sent-frame store; execute one command.
// ============================================================================
module gbn_back #(
    parameter int SEQ_BITS    = 3,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  gbn_pkg::t_op           i_cmd_op,
    input  logic [HANDLE_BITS-1:0] i_cmd_data,
    input  logic [SEQ_BITS-1:0]    i_cmd_seq,
    input  logic [SEQ_BITS-1:0]    i_cmd_ack,
    output logic                   o_cmd_pop,
    output logic                   o_res_push,
    input  logic                   i_res_full,
    output gbn_pkg::t_res_ctrl     o_res_ctrl,
    output logic [HANDLE_BITS-1:0] o_res_handle,
    output logic [SEQ_BITS-1:0]    o_res_seq,
    output logic [SEQ_BITS-1:0]    o_res_ack,
    output logic [SEQ_BITS-1:0]    o_res_outs
);

    localparam int                DEPTH   = 2 ** SEQ_BITS;
    localparam logic [SEQ_BITS-1:0] WIN_MAX = {SEQ_BITS{1'b1}};
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

    logic [HANDLE_BITS-1:0] r_store [DEPTH];
    logic [SEQ_BITS-1:0]    r_next, n_next;
    logic [SEQ_BITS-1:0]    r_oldest, n_oldest;
    logic [SEQ_BITS-1:0]    r_expected, n_expected;
    logic [SEQ_BITS-1:0]    r_idx, n_idx;
    logic [SEQ_BITS-1:0]    w_outs, w_slide, w_retx_seq, w_new_outs;
    logic                   w_go, w_done, w_store_wr;

    assign w_go       = i_cmd_valid && !i_res_full;
    assign w_outs     = r_next - r_oldest;
    assign w_slide    = i_cmd_ack - r_oldest;
    assign w_retx_seq = r_oldest + r_idx;

    always_comb begin
        n_next     = r_next;
        n_oldest   = r_oldest;
        n_expected = r_expected;
        n_idx      = r_idx;
        w_done     = 1'b1;
        w_store_wr = 1'b0;
        o_res_ctrl.kind = gbn_pkg::KIND_STATUS;
        o_res_ctrl.last = 1'b1;
        o_res_handle    = '0;
        o_res_seq       = '0;
        case (i_cmd_op)
            gbn_pkg::OP_SEND: begin
                if (w_outs != WIN_MAX) begin
                    w_store_wr      = 1'b1;
                    n_next          = r_next + SEQ_ONE;
                    o_res_ctrl.kind = gbn_pkg::KIND_TX;
                    o_res_handle    = i_cmd_data;
                    o_res_seq       = r_next;
                end
            end
            gbn_pkg::OP_PEER: begin
                if (w_slide <= w_outs) begin
                    n_oldest = r_oldest + w_slide;
                end
                if (i_cmd_seq == r_expected) begin
                    n_expected      = r_expected + SEQ_ONE;
                    o_res_ctrl.kind = gbn_pkg::KIND_DELIVER;
                    o_res_handle    = i_cmd_data;
                    o_res_seq       = i_cmd_seq;
                end
            end
            gbn_pkg::OP_TIMEOUT: begin
                if (w_outs != '0) begin
                    // step through the window, hold the command until the last frame
                    w_done          = (r_idx == w_outs - SEQ_ONE);
                    n_idx           = w_done ? '0 : r_idx + SEQ_ONE;
                    o_res_ctrl.kind = gbn_pkg::KIND_RETX;
                    o_res_ctrl.last = w_done;
                    o_res_handle    = r_store[w_retx_seq];
                    o_res_seq       = w_retx_seq;
                end
            end
            gbn_pkg::OP_RESET: begin
                n_next     = '0;
                n_oldest   = '0;
                n_expected = '0;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_new_outs             = n_next - n_oldest;
        o_res_outs             = w_new_outs;
        o_res_ack              = n_expected;
        o_res_ctrl.window_full = (w_new_outs == WIN_MAX);
    end

    assign o_res_push = w_go;
    assign o_cmd_pop  = w_go && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next     <= '0;
            r_oldest   <= '0;
            r_expected <= '0;
            r_idx      <= '0;
        end else if (w_go) begin
            r_next     <= n_next;
            r_oldest   <= n_oldest;
            r_expected <= n_expected;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_store_wr) begin
            r_store[r_next] <= i_cmd_data;
        end
    end

endmodule

// ----- design/go_back_n_arq_endpoint_core.sv -----
// Path: registered command queue, engine, registered result queue, output ports.
// The engine takes a send, peer-frame or reset command while the result queue has
// room; a timeout holds it for one retransmit per outstanding frame (at most
// 2^SEQ_BITS - 1), set by the single store read port of the back-end engine.
// Reset: synchronous, active low; clears both queues and all window counters.
// The sent-frame store is not cleared and is only read where it was written.
// ============================================================================
// go_back_n_arq_endpoint_core: Go-Back-N sliding-window endpoint
// Front intake queue, protocol engine and result queue with piggybacked acks.
// ============================================================================
module go_back_n_arq_endpoint_core #(
    parameter int SEQ_BITS    = 3,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input side
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_operation,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    input  logic [HANDLE_BITS-1:0] i_rx_payload,
    input  logic [SEQ_BITS-1:0]    i_rx_seq,
    input  logic [SEQ_BITS-1:0]    i_rx_ack,
    // result side
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_result_kind,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [SEQ_BITS-1:0]    o_out_seq,
    output logic [SEQ_BITS-1:0]    o_piggy_ack,
    output logic                   o_window_full,
    output logic [SEQ_BITS-1:0]    o_outstanding,
    output logic                   o_last
);

    localparam int CTRL_W = $bits(gbn_pkg::t_res_ctrl);
    localparam int RES_W  = CTRL_W + HANDLE_BITS + 3 * SEQ_BITS;

    // command path between the front and the engine
    logic                   w_cmd_valid;
    gbn_pkg::t_op           w_cmd_op;
    logic [HANDLE_BITS-1:0] w_cmd_data;
    logic [SEQ_BITS-1:0]    w_cmd_seq;
    logic [SEQ_BITS-1:0]    w_cmd_ack;
    logic                   w_cmd_pop;

    // result path between the engine and the output queue
    logic                   w_res_push;
    logic                   w_res_full;
    gbn_pkg::t_res_ctrl     w_res_ctrl;
    logic [HANDLE_BITS-1:0] w_res_handle;
    logic [SEQ_BITS-1:0]    w_res_seq;
    logic [SEQ_BITS-1:0]    w_res_ack;
    logic [SEQ_BITS-1:0]    w_res_outs;
    logic [RES_W-1:0]       w_res_word, w_out_word;
    gbn_pkg::t_res_ctrl     w_out_ctrl;

    // Front: accept the input transaction, pick the relevant handle, queue it.
    gbn_front #(
        .SEQ_BITS    (SEQ_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_frame_handle (i_frame_handle),
        .i_rx_payload   (i_rx_payload),
        .i_rx_seq       (i_rx_seq),
        .i_rx_ack       (i_rx_ack),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd_op       (w_cmd_op),
        .o_cmd_data     (w_cmd_data),
        .o_cmd_seq      (w_cmd_seq),
        .o_cmd_ack      (w_cmd_ack),
        .i_cmd_pop      (w_cmd_pop)
    );

    // Engine: advance the window, store sent handles, expand timeouts into
    // one retransmit per outstanding frame, oldest first.
    gbn_back #(
        .SEQ_BITS    (SEQ_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd_op     (w_cmd_op),
        .i_cmd_data   (w_cmd_data),
        .i_cmd_seq    (w_cmd_seq),
        .i_cmd_ack    (w_cmd_ack),
        .o_cmd_pop    (w_cmd_pop),
        .o_res_push   (w_res_push),
        .i_res_full   (w_res_full),
        .o_res_ctrl   (w_res_ctrl),
        .o_res_handle (w_res_handle),
        .o_res_seq    (w_res_seq),
        .o_res_ack    (w_res_ack),
        .o_res_outs   (w_res_outs)
    );

    // Result queue: decouple the engine from a stalled consumer.
    assign w_res_word = {w_res_ctrl, w_res_handle, w_res_seq, w_res_ack, w_res_outs};

    gbn_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_word),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out_word)
    );

    // Unpack the head of the result queue onto the ports.
    assign w_out_ctrl    = gbn_pkg::t_res_ctrl'(w_out_word[RES_W-1 -: CTRL_W]);
    assign o_result_kind = w_out_ctrl.kind;
    assign o_window_full = w_out_ctrl.window_full;
    assign o_last        = w_out_ctrl.last;
    assign o_out_handle  = w_out_word[3*SEQ_BITS +: HANDLE_BITS];
    assign o_out_seq     = w_out_word[2*SEQ_BITS +: SEQ_BITS];
    assign o_piggy_ack   = w_out_word[SEQ_BITS +: SEQ_BITS];
    assign o_outstanding = w_out_word[0 +: SEQ_BITS];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The engine never drops a result into a full queue.
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    // A command retires only together with its final result.
    a_pop_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_res_push && w_res_ctrl.last))
        else $error("command retired without its last result");

    // Every result other than a retransmit closes its transaction.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res_ctrl.kind != gbn_pkg::KIND_RETX) |-> w_res_ctrl.last)
        else $error("non-retransmit result without last");

    // Window-full flag on the output agrees with the outstanding count.
    a_window_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_window_full == (&o_outstanding)))
        else $error("window_full disagrees with outstanding");

endmodule

// ----- verif/go_back_n_arq_endpoint_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// go_back_n_arq_endpoint_core_test: self-checking bench for the GBN endpoint
// A directed table covers reset, window extremes and every status case. A
// random run follows, mostly well-formed traffic. A local window model checks
// every popped result in order while both queue sides stall at random.
// ============================================================================
module go_back_n_arq_endpoint_core_test;

    localparam int          SEQ_W          = 3;
    localparam int          HANDLE_W       = 16;
    localparam logic [2:0]  WIN_LIMIT      = 3'd7;    // 2^SEQ_W - 1 frames in flight
    localparam int          RANDOM_ITEMS   = 156;
    localparam int          WATCHDOG_LIMIT = 2000;    // cycles without any transaction
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          MAX_REPORTS    = 10;

    // One result transaction as the block presents it.
    typedef struct packed {
        gbn_pkg::t_kind      kind;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic [SEQ_W-1:0]    ack;
        logic                wfull;
        logic [SEQ_W-1:0]    outst;
        logic                last;
    } gbn_result_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        gbn_pkg::t_op        op;
        logic [HANDLE_W-1:0] fh;
        logic [HANDLE_W-1:0] pl;
        logic [SEQ_W-1:0]    sq;
        logic [SEQ_W-1:0]    ak;
        logic                typed;
        gbn_result_t         want;
    } plan_row_t;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                push           = 1'b0;
    logic                full;
    logic [1:0]          i_operation    = '0;
    logic [HANDLE_W-1:0] i_frame_handle = '0;
    logic [HANDLE_W-1:0] i_rx_payload   = '0;
    logic [SEQ_W-1:0]    i_rx_seq       = '0;
    logic [SEQ_W-1:0]    i_rx_ack       = '0;
    logic                empty;
    logic                pop            = 1'b0;
    logic [1:0]          o_result_kind;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [SEQ_W-1:0]    o_out_seq;
    logic [SEQ_W-1:0]    o_piggy_ack;
    logic                o_window_full;
    logic [SEQ_W-1:0]    o_outstanding;
    logic                o_last;

    // Window model state.
    logic [SEQ_W-1:0]    next_seq;
    logic [SEQ_W-1:0]    base_seq;
    logic [SEQ_W-1:0]    rx_expect;
    logic [HANDLE_W-1:0] sent_handles [0:(1<<SEQ_W)-1];

    gbn_result_t         pending_results [$];
    plan_row_t           directed_plan [$];

    bit no_idle        = 1'b0;
    int idle_cycles    = 0;
    int errors         = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int retx_seen      = 0;
    int delivered_seen = 0;
    int wfull_seen     = 0;

    go_back_n_arq_endpoint_core #(
        .SEQ_BITS    (SEQ_W),
        .HANDLE_BITS (HANDLE_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_frame_handle (i_frame_handle),
        .i_rx_payload   (i_rx_payload),
        .i_rx_seq       (i_rx_seq),
        .i_rx_ack       (i_rx_ack),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_out_handle   (o_out_handle),
        .o_out_seq      (o_out_seq),
        .o_piggy_ack    (o_piggy_ack),
        .o_window_full  (o_window_full),
        .o_outstanding  (o_outstanding),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Queue one expected result; window flags reflect the state after the step.
    function automatic void emit_result(gbn_pkg::t_kind kind, logic [HANDLE_W-1:0] handle,
                                        logic [SEQ_W-1:0] seq, logic last);
        gbn_result_t r;
        logic [SEQ_W-1:0] outst;
        outst   = next_seq - base_seq;
        r.kind  = kind;
        r.handle = handle;
        r.seq   = seq;
        r.ack   = rx_expect;
        r.wfull = (outst == WIN_LIMIT);
        r.outst = outst;
        r.last  = last;
        pending_results.push_back(r);
    endfunction

    // Advance the window model by one accepted input transaction.
    function automatic void predict_window(gbn_pkg::t_op op, logic [HANDLE_W-1:0] fh,
                                           logic [HANDLE_W-1:0] pl,
                                           logic [SEQ_W-1:0] sq, logic [SEQ_W-1:0] ak);
        logic [SEQ_W-1:0] in_flight;
        logic [SEQ_W-1:0] slide;
        logic [SEQ_W-1:0] s;
        logic             in_order;
        in_flight = next_seq - base_seq;
        case (op)
            gbn_pkg::OP_SEND: begin
                if (in_flight == WIN_LIMIT) begin
                    // Drop the frame, report the full window.
                    emit_result(gbn_pkg::KIND_STATUS, '0, '0, 1'b1);
                end else begin
                    s = next_seq;
                    sent_handles[s] = fh;
                    next_seq = next_seq + 1'b1;
                    emit_result(gbn_pkg::KIND_TX, fh, s, 1'b1);
                end
            end
            gbn_pkg::OP_PEER: begin
                in_order = (sq == rx_expect);
                slide    = ak - base_seq;
                if (in_order) rx_expect = rx_expect + 1'b1;
                // Hold the window when the ack lies outside the frames in flight.
                if (slide <= in_flight) base_seq = base_seq + slide;
                if (in_order) emit_result(gbn_pkg::KIND_DELIVER, pl, sq, 1'b1);
                else          emit_result(gbn_pkg::KIND_STATUS, '0, '0, 1'b1);
            end
            gbn_pkg::OP_TIMEOUT: begin
                if (in_flight == 0) begin
                    emit_result(gbn_pkg::KIND_STATUS, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < in_flight; i++) begin
                        s = base_seq + i[SEQ_W-1:0];
                        emit_result(gbn_pkg::KIND_RETX, sent_handles[s], s,
                                    i == in_flight - 1);
                    end
                end
            end
            default: begin
                // Clear the counters, keep the stored handles.
                next_seq  = '0;
                base_seq  = '0;
                rx_expect = '0;
                emit_result(gbn_pkg::KIND_STATUS, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic plan_row_t make_row(gbn_pkg::t_op op, logic [HANDLE_W-1:0] fh,
                                           logic [HANDLE_W-1:0] pl,
                                           logic [SEQ_W-1:0] sq, logic [SEQ_W-1:0] ak,
                                           logic typed, gbn_pkg::t_kind kind,
                                           logic [HANDLE_W-1:0] handle,
                                           logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                                           logic wfull, logic [SEQ_W-1:0] outst);
        plan_row_t row;
        row.op          = op;
        row.fh          = fh;
        row.pl          = pl;
        row.sq          = sq;
        row.ak          = ak;
        row.typed       = typed;
        row.want.kind   = kind;
        row.want.handle = handle;
        row.want.seq    = seq;
        row.want.ack    = ack;
        row.want.wfull  = wfull;
        row.want.outst  = outst;
        row.want.last   = 1'b1;
        return row;
    endfunction

    // Offer one input transaction, hold it until accepted, then predict it.
    task automatic offer_transaction(gbn_pkg::t_op op, logic [HANDLE_W-1:0] fh,
                                     logic [HANDLE_W-1:0] pl,
                                     logic [SEQ_W-1:0] sq, logic [SEQ_W-1:0] ak,
                                     logic typed, gbn_result_t want);
        while (!no_idle && $urandom_range(99) < 18) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_operation    <= op;
        i_frame_handle <= fh;
        i_rx_payload   <= pl;
        i_rx_seq       <= sq;
        i_rx_ack       <= ak;
        do @(posedge i_clk); while (full);
        items_accepted++;
        predict_window(op, fh, pl, sq, ak);
        // Typed rows replace the model's single result with the hand-written one.
        if (typed) pending_results[pending_results.size() - 1] = want;
    endtask

    // Pop at random and compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        gbn_result_t seen;
        gbn_result_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                seen.kind   = gbn_pkg::t_kind'(o_result_kind);
                seen.handle = o_out_handle;
                seen.seq    = o_out_seq;
                seen.ack    = o_piggy_ack;
                seen.wfull  = o_window_full;
                seen.outst  = o_outstanding;
                seen.last   = o_last;
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: kind %0d handle %h seq %0d",
                                 seen.kind, seen.handle, seen.seq);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("mismatch at result %0d: expected kind %0d handle %h",
                                     results_seen, want.kind, want.handle);
                            $display("  seq %0d ack %0d wfull %0b outst %0d last %0b",
                                     want.seq, want.ack, want.wfull, want.outst, want.last);
                            $display("  got kind %0d handle %h seq %0d ack %0d",
                                     seen.kind, seen.handle, seen.seq, seen.ack);
                            $display("  wfull %0b outst %0d last %0b",
                                     seen.wfull, seen.outst, seen.last);
                        end
                    end
                end
                if (seen.kind == gbn_pkg::KIND_RETX)    retx_seen++;
                if (seen.kind == gbn_pkg::KIND_DELIVER) delivered_seen++;
                if (seen.wfull)                         wfull_seen++;
            end
            pop <= (no_idle || $urandom_range(99) >= 18);
        end
    end

    // Count cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        plan_row_t           row;
        gbn_pkg::t_op        op;
        logic [HANDLE_W-1:0] fh;
        logic [HANDLE_W-1:0] pl;
        logic [SEQ_W-1:0]    sq;
        logic [SEQ_W-1:0]    ak;
        logic [SEQ_W-1:0]    in_flight;
        int                  pick;
        int                  directed_count;

        next_seq  = '0;
        base_seq  = '0;
        rx_expect = '0;

        // Directed table: empty window, fill to the limit, drop on full, retransmit
        // the full window, out-of-order peer frame, ack outside the window,
        // sequence wrap, and a session reset with all other fields at their maximum.
        directed_plan.push_back(make_row(gbn_pkg::OP_TIMEOUT, 16'h0000, 16'h0000, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_STATUS, 16'h0000, 3'd0, 3'd0,
                                1'b0, 3'd0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'h0000, 16'hFFFF, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_DELIVER, 16'hFFFF, 3'd0, 3'd1,
                                1'b0, 3'd0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h0000, 16'hFFFF, 3'd7,
                                3'd7, 1'b1, gbn_pkg::KIND_TX, 16'h0000, 3'd0, 3'd1,
                                1'b0, 3'd1));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'hFFFF, 16'h0000, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_TX, 16'hFFFF, 3'd1, 3'd1,
                                1'b0, 3'd2));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'hA5A5, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h5A5A, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h1234, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h8001, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h7FFE, 16'h0000, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_TX, 16'h7FFE, 3'd6, 3'd1,
                                1'b1, 3'd7));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h4321, 16'h0000, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_STATUS, 16'h0000, 3'd0, 3'd1,
                                1'b1, 3'd7));
        directed_plan.push_back(make_row(gbn_pkg::OP_TIMEOUT, 16'h0000, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_RETX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'h0000, 16'hBEEF, 3'd5,
                                3'd3, 1'b0, gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'h0000, 16'h0001, 3'd1,
                                3'd0, 1'b0, gbn_pkg::KIND_DELIVER, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'h0000, 16'h8000, 3'd2,
                                3'd7, 1'b0, gbn_pkg::KIND_DELIVER, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_TIMEOUT, 16'h0000, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h1111, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h2222, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'h3333, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_TX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_TIMEOUT, 16'h0000, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_RETX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'hFFFF, 16'h0000, 3'd7,
                                3'd2, 1'b0, gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_RESET, 16'hFFFF, 16'hFFFF, 3'd7,
                                3'd7, 1'b1, gbn_pkg::KIND_STATUS, 16'h0000, 3'd0, 3'd0,
                                1'b0, 3'd0));
        directed_plan.push_back(make_row(gbn_pkg::OP_SEND, 16'hFFFF, 16'h0000, 3'd0,
                                3'd0, 1'b1, gbn_pkg::KIND_TX, 16'hFFFF, 3'd0, 3'd0,
                                1'b0, 3'd1));
        directed_plan.push_back(make_row(gbn_pkg::OP_TIMEOUT, 16'h0000, 16'h0000, 3'd0,
                                3'd0, 1'b0, gbn_pkg::KIND_RETX, '0, '0, '0, 1'b0, '0));
        directed_plan.push_back(make_row(gbn_pkg::OP_PEER, 16'h0000, 16'h0000, 3'd7,
                                3'd7, 1'b0, gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0, '0));
        directed_count = directed_plan.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < directed_plan.size(); k++) begin
            row = directed_plan[k];
            offer_transaction(row.op, row.fh, row.pl, row.sq, row.ak, row.typed, row.want);
        end

        // Random traffic: sends, peer frames mostly in order with acks in the window,
        // plus stray sequence numbers and acks, timeouts and the odd session reset.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 70) begin
                // Hold off until every expected result has drained.
                push <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            no_idle = (n >= 100 && n < 140);
            in_flight = next_seq - base_seq;
            fh   = HANDLE_W'($urandom_range(16'hFFFF));
            pl   = HANDLE_W'($urandom_range(16'hFFFF));
            sq   = SEQ_W'($urandom_range(7));
            ak   = SEQ_W'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 42) begin
                op = gbn_pkg::OP_SEND;
            end else if (pick < 78) begin
                op = gbn_pkg::OP_PEER;
                if ($urandom_range(9) < 8) sq = rx_expect;
                if ($urandom_range(9) < 8)
                    ak = base_seq + SEQ_W'($urandom_range(in_flight));
            end else if (pick < 94) begin
                op = gbn_pkg::OP_TIMEOUT;
            end else begin
                op = gbn_pkg::OP_RESET;
            end
            offer_transaction(op, fh, pl, sq, ak, 1'b0, '0);
        end
        no_idle = 1'b0;
        push <= 1'b0;

        // Drain, then keep the clock running to catch stray results.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d input transactions (%0d directed), %0d results popped.",
                 items_accepted, directed_count, results_seen);
        $display("Saw %0d retransmits, %0d deliveries, %0d window-full reports, %0d mismatches.",
                 retx_seen, delivered_seen, wfull_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
